// ----- hdl/mwdg_pkg.sv -----
// ----------------------------------------------------------------------------
// mwdg_pkg
// Shared types and constants for the multi-waveform DAC generator.
// ----------------------------------------------------------------------------
package mwdg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAW_HOLD_TICKS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINE_HOLD_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_HOLD_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAW_STEP            = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_HALF_SAMPLES = 3'd5;

  typedef enum logic [1:0] {
    MODE_SAW    = 2'd0,
    MODE_SINE   = 2'd1,
    MODE_SQUARE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [5:0]  gap_ticks;
    logic [3:0]  saw_hold_ticks;
    logic [3:0]  sine_hold_ticks;
    logic [3:0]  square_hold_ticks;
    logic [11:0] saw_step;
    logic [9:0]  square_half_samples;
  } cfg_t;

  localparam cfg_t CFG_DEFAULT = '{
    gap_ticks:           6'd30,
    saw_hold_ticks:      4'd3,
    sine_hold_ticks:     4'd6,
    square_hold_ticks:   4'd1,
    saw_step:            12'd43,
    square_half_samples: 10'd208
  };

  typedef struct packed {
    logic        tick;
    logic        button_level;
    logic        adc_valid;
    logic [11:0] adc_code;
  } item_t;

  typedef struct packed {
    logic [11:0] dac_code;
    mode_t       waveform;
    logic [1:0]  amp_hundreds;
    logic [3:0]  amp_tens;
    logic [3:0]  amp_ones;
  } result_t;

endpackage

// ----- hdl/multi_waveform_dac_generator.sv -----
// output: each result is registered in out_r, or in skid_r while the output stalls
// throughput: one request per cycle while the skid entry is empty; a two-entry output
//   buffer keeps in_tready high for one more request while the downstream side stalls
// reset (rst_n low, synchronous): sequencer returns to sawtooth in the gap,
//   amplitude and dac code clear, registers take their defaults, buffer empties
// ----------------------------------------------------------------------------
// multi_waveform_dac_generator
// Sawtooth, sine and square generator for a 12-bit DAC with amplitude readout.
// ----------------------------------------------------------------------------
module multi_waveform_dac_generator #(
  parameter int SINE_POINTS    = 70,
  parameter int SINE_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: tick [0], button_level [1], adc_code [13:2], zero fill [15:14]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,
  // in_tuser: adc_valid [0]
  input  logic                               in_tuser,
  // out_tdata: dac_code [11:0], amp_hundreds [13:12], amp_tens [17:14],
  //            amp_ones [21:18], zero fill [23:22]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,
  // out_tuser: waveform [1:0]
  output logic [1:0]                         out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mwdg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mwdg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  mwdg_pkg::cfg_t    cfg_r;
  mwdg_pkg::item_t   item;
  mwdg_pkg::result_t res;
  logic              push;
  logic              pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mwdg_pkg::CFG_DEFAULT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mwdg_pkg::REG_GAP_TICKS:           cfg_r.gap_ticks           <= cfg_data[5:0];
        mwdg_pkg::REG_SAW_HOLD_TICKS:      cfg_r.saw_hold_ticks      <= cfg_data[3:0];
        mwdg_pkg::REG_SINE_HOLD_TICKS:     cfg_r.sine_hold_ticks     <= cfg_data[3:0];
        mwdg_pkg::REG_SQUARE_HOLD_TICKS:   cfg_r.square_hold_ticks   <= cfg_data[3:0];
        mwdg_pkg::REG_SAW_STEP:            cfg_r.saw_step            <= cfg_data;
        mwdg_pkg::REG_SQUARE_HALF_SAMPLES: cfg_r.square_half_samples <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign item.tick         = in_tdata[0];
  assign item.button_level = in_tdata[1];
  assign item.adc_code     = in_tdata[13:2];
  assign item.adc_valid    = in_tuser;

  assign push = in_tvalid & in_tready;

  mwdg_core #(
    .SINE_POINTS    (SINE_POINTS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (push),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // output register plus skid entry
  mwdg_pkg::result_t out_r, out_nxt;
  mwdg_pkg::result_t skid_r, skid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;

  assign in_tready = ~skid_valid_r;
  assign pop       = out_valid_r & out_tready;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push && (!out_valid_r || pop)) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (push) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.amp_ones, out_r.amp_tens, out_r.amp_hundreds,
                       out_r.dac_code};
  assign out_tuser  = out_r.waveform;

endmodule

// ----- hdl/mwdg_core.sv -----
// ----------------------------------------------------------------------------
// mwdg_core
// Waveform sequencer state, sample computation and amplitude readout.
// ----------------------------------------------------------------------------
module mwdg_core #(
  parameter int SINE_POINTS    = 70,
  parameter int SINE_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  mwdg_pkg::item_t   item,
  input  mwdg_pkg::cfg_t    cfg,
  output mwdg_pkg::result_t res
);

  localparam int IW        = $clog2(SINE_POINTS);
  localparam int ROM_DEPTH = 2 ** IW;
  localparam int BW        = (SINE_FRAC_BITS > 12) ? SINE_FRAC_BITS : 12;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [11:0] DAC_FULL     = 12'd4095;
  localparam logic [19:0] DISP_RECIP   = 20'd682010;  // 10 * ceil(2^23 / 123)
  localparam int          DISP_SHIFT   = 23;

  logic [SINE_FRAC_BITS-1:0] sine_tab [ROM_DEPTH];

  // clipped sine in Q30, quarter-wave series to 15th order
  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_sine
    localparam longint unsigned X  =
      ((64'd62832 * 64'(g)) << 30) / (64'd10000 * 64'(SINE_POINTS));
    localparam longint unsigned Y  = (X >= PI_Q30) ? 64'd0 :
                                     (X > HALF_PI_Q30) ? (PI_Q30 - X) : X;
    localparam longint unsigned Y2 = (Y * Y) >> 30;
    // taylor terms, each divided by (2k)(2k+1)
    localparam longint unsigned T1 = ((Y  * Y2) >> 30) / 64'd6;
    localparam longint unsigned T2 = ((T1 * Y2) >> 30) / 64'd20;
    localparam longint unsigned T3 = ((T2 * Y2) >> 30) / 64'd42;
    localparam longint unsigned T4 = ((T3 * Y2) >> 30) / 64'd72;
    localparam longint unsigned T5 = ((T4 * Y2) >> 30) / 64'd110;
    localparam longint unsigned T6 = ((T5 * Y2) >> 30) / 64'd156;
    localparam longint unsigned T7 = ((T6 * Y2) >> 30) / 64'd210;
    localparam longint ACC = longint'(Y) - longint'(T1) + longint'(T2) - longint'(T3)
                             + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
    localparam longint POS = (ACC < 0) ? 64'sd0 : ACC;
    localparam longint SAT = (POS > longint'(Q30_ONE - 64'd1)) ?
                             longint'(Q30_ONE - 64'd1) : POS;
    localparam logic [SINE_FRAC_BITS-1:0] ENTRY =
      (X >= PI_Q30) ? '0 : SINE_FRAC_BITS'(SAT >>> (30 - SINE_FRAC_BITS));
    assign sine_tab[g] = ENTRY;
  end

  // state
  mwdg_pkg::mode_t mode_r, mode_nxt;
  logic            in_gap_r, in_gap_nxt;
  logic [5:0]      hold_r, hold_nxt;
  logic [11:0]     idx_r, idx_nxt;
  logic [11:0]     amp_r, amp_nxt;
  logic [11:0]     dac_r, dac_nxt;
  logic [8:0]      disp_r, disp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mwdg_pkg::MODE_SAW;
      in_gap_r <= 1'b1;
      hold_r   <= '0;
      idx_r    <= '0;
      amp_r    <= '0;
      dac_r    <= '0;
      disp_r   <= '0;
    end else if (en) begin
      mode_r   <= mode_nxt;
      in_gap_r <= in_gap_nxt;
      hold_r   <= hold_nxt;
      idx_r    <= idx_nxt;
      amp_r    <= amp_nxt;
      dac_r    <= dac_nxt;
      disp_r   <= disp_nxt;
    end
  end

  // amplitude and readout value
  logic [31:0] disp_prod;
  logic [11:0] amp_new;

  assign amp_new   = DAC_FULL - item.adc_code;
  assign disp_prod = 32'(amp_new) * 32'(DISP_RECIP);
  assign amp_nxt   = item.adc_valid ? amp_new : amp_r;
  assign disp_nxt  = item.adc_valid ? disp_prod[DISP_SHIFT +: 9] : disp_r;

  // period stepping
  logic [3:0]  hold_sel;
  logic [3:0]  hold_lim;
  logic [11:0] step;
  logic [12:0] nxt_idx;
  logic [9:0]  half_eff;
  logic        period_end;
  logic [11:0] use_idx;

  always_comb begin
    unique case (mode_r)
      mwdg_pkg::MODE_SAW:  hold_sel = cfg.saw_hold_ticks;
      mwdg_pkg::MODE_SINE: hold_sel = cfg.sine_hold_ticks;
      default:             hold_sel = cfg.square_hold_ticks;
    endcase
  end

  assign hold_lim = (hold_sel == 4'd0) ? 4'd1 : hold_sel;
  assign half_eff = (cfg.square_half_samples == 10'd0) ? 10'd1 : cfg.square_half_samples;
  assign step     = (mode_r != mwdg_pkg::MODE_SAW) ? 12'd1 :
                    (cfg.saw_step == 12'd0) ? 12'd1 : cfg.saw_step;
  assign nxt_idx  = {1'b0, idx_r} + {1'b0, step};

  always_comb begin
    unique case (mode_r)
      mwdg_pkg::MODE_SAW:  period_end = nxt_idx[12];
      mwdg_pkg::MODE_SINE: period_end = (nxt_idx >= 13'(SINE_POINTS));
      default:             period_end = (nxt_idx >= {2'b00, half_eff, 1'b0});
    endcase
  end

  // first sample of a period is index zero
  assign use_idx = in_gap_r ? 12'd0 : nxt_idx[11:0];

  // sample value: one shared multiplier for sawtooth and sine
  logic [SINE_FRAC_BITS-1:0] rom_val;
  logic [BW-1:0]             mul_b;
  logic [12+BW-1:0]          prod;
  logic [11:0]               saw_q;
  logic [12:0]               saw_r;
  logic [12:0]               saw_val;
  logic [11:0]               sample_val;

  assign rom_val = (use_idx < 12'(SINE_POINTS)) ? sine_tab[use_idx[IW-1:0]] : '0;
  assign mul_b   = (mode_r == mwdg_pkg::MODE_SAW) ? BW'(use_idx) : BW'(rom_val);
  assign prod    = (12+BW)'(amp_nxt) * (12+BW)'(mul_b);

  // divide by 4095: estimate p >> 12, then fold the remainder back
  assign saw_q   = prod[23:12];
  assign saw_r   = {1'b0, prod[11:0]} + {1'b0, saw_q};
  assign saw_val = {1'b0, saw_q} + ((saw_r == 13'd8190) ? 13'd2 :
                                    (saw_r >= 13'd4095) ? 13'd1 : 13'd0);

  always_comb begin
    unique case (mode_r)
      mwdg_pkg::MODE_SAW:  sample_val = saw_val[11:0];
      mwdg_pkg::MODE_SINE: sample_val = prod[SINE_FRAC_BITS +: 12];
      default:             sample_val = (use_idx < {2'b00, half_eff}) ? amp_nxt : 12'd0;
    endcase
  end

  // sequencer next state
  logic [5:0] gap_hc;
  logic [6:0] play_hc;

  assign gap_hc  = (hold_r < cfg.gap_ticks) ? hold_r + 6'd1 : hold_r;
  assign play_hc = {1'b0, hold_r} + 7'd1;

  always_comb begin
    mode_nxt   = mode_r;
    in_gap_nxt = in_gap_r;
    hold_nxt   = hold_r;
    idx_nxt    = idx_r;
    dac_nxt    = dac_r;
    if (item.tick) begin
      if (in_gap_r) begin
        if (gap_hc >= cfg.gap_ticks) begin
          in_gap_nxt = 1'b0;
          hold_nxt   = '0;
          idx_nxt    = '0;
          dac_nxt    = sample_val;
        end else begin
          hold_nxt = gap_hc;
        end
      end else if (play_hc >= {3'b000, hold_lim}) begin
        hold_nxt = '0;
        if (period_end) begin
          in_gap_nxt = 1'b1;
          idx_nxt    = '0;
          if (!item.button_level) begin
            unique case (mode_r)
              mwdg_pkg::MODE_SAW:  mode_nxt = mwdg_pkg::MODE_SINE;
              mwdg_pkg::MODE_SINE: mode_nxt = mwdg_pkg::MODE_SQUARE;
              default:             mode_nxt = mwdg_pkg::MODE_SAW;
            endcase
          end
        end else begin
          idx_nxt = nxt_idx[11:0];
          dac_nxt = sample_val;
        end
      end else begin
        hold_nxt = play_hc[5:0];
      end
    end
  end

  // decimal digits of the readout
  logic [1:0] hund;
  logic [6:0] rem;
  logic [3:0] tens;
  logic [6:0] ones;

  always_comb begin
    priority if (disp_nxt >= 9'd300) begin
      hund = 2'd3;
      rem  = 7'(disp_nxt - 9'd300);
    end else if (disp_nxt >= 9'd200) begin
      hund = 2'd2;
      rem  = 7'(disp_nxt - 9'd200);
    end else if (disp_nxt >= 9'd100) begin
      hund = 2'd1;
      rem  = 7'(disp_nxt - 9'd100);
    end else begin
      hund = 2'd0;
      rem  = 7'(disp_nxt);
    end
    tens = 4'd0;
    for (int t = 1; t < 10; t++) begin
      if (rem >= 7'(t * 10)) begin
        tens = 4'(t);
      end
    end
    ones = rem - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
  end

  assign res.dac_code     = dac_nxt;
  assign res.waveform     = mode_nxt;
  assign res.amp_hundreds = hund;
  assign res.amp_tens     = tens;
  assign res.amp_ones     = ones[3:0];

endmodule

// ----- hdl/mwdg_checker.sv -----
// ----------------------------------------------------------------------------
// mwdg_checker
// Port-level checks for the multi-waveform DAC generator.
// ----------------------------------------------------------------------------
module mwdg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [15:0]                     in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [23:0]                     out_tdata,
  input logic [1:0]                      out_tuser,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [mwdg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [mwdg_pkg::CFG_DATA_W-1:0] cfg_data
);

  // no result is left over from before reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // input backpressure only while a result is waiting
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // a request taken with the output empty shows its result next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> out_tvalid)
    else $error("result missing one cycle after request");

  // the buffer has two entries: a full buffer with the output stalled keeps ready low
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && !out_tready |=> !in_tready)
    else $error("buffer drained without a result taken");

endmodule

bind multi_waveform_dac_generator mwdg_checker u_mwdg_checker (.*);
